>>> hdl/bcmp_pkg.sv
// Shared constants and types for the binomial coefficient block.
`default_nettype none
package bcmp_pkg;
   localparam int unsigned MAX_N = 1023;
   localparam int unsigned MODULUS = 1000000007;
   localparam int RES_W = $clog2(MODULUS);
   localparam int IDX_W = $clog2(MAX_N + 1);
   localparam int K_W = $clog2(MAX_N + 2);
   localparam int CNT_W = $clog2(RES_W);
   localparam int IN_W = 12;
   localparam int VALUE_W = 30;
   localparam int MM_LAT = 6;
   localparam logic [RES_W-1:0] P_VAL = RES_W'(MODULUS);
   localparam logic [63:0] MU_FULL = (64'd1 << (2 * RES_W)) / 64'(MODULUS);
   localparam logic [RES_W:0] MU = MU_FULL[RES_W:0];

   typedef struct packed {
      logic valid;
      logic kind;
      logic ok;
      logic oor;
   } ctl_type;
endpackage
`default_nettype wire

>>> hdl/binomial_coefficient_mod_prime.sv
// Top level: table build sequencer, lookup pipeline and two modular multipliers.
// After reset, busy stays high while the inverse, factorial and inverse factorial
// tables are built up to entry 1023. Then one request is taken every cycle; it
// passes the input register, the table reads, both multipliers and the output
// register before its result strobe. The receiver cannot stall the pipeline.
// Reset is synchronous and restarts the build.
`default_nettype none
module binomial_coefficient_mod_prime
   import bcmp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_type,
   input  wire logic signed [IN_W-1:0] req_n,
   input  wire logic signed [IN_W-1:0] req_r,
   output logic                        rsp_valid,
   output logic [VALUE_W-1:0]          rsp_value,
   output logic                        rsp_out_of_range
);
   localparam logic [3:0] ST_INIT0 = 4'd0;
   localparam logic [3:0] ST_INIT1 = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_RD    = 4'd3;
   localparam logic [3:0] ST_MINV  = 4'd4;
   localparam logic [3:0] ST_WINV  = 4'd5;
   localparam logic [3:0] ST_MFACT = 4'd6;
   localparam logic [3:0] ST_WFACT = 4'd7;
   localparam logic [3:0] ST_MFINV = 4'd8;
   localparam logic [3:0] ST_WFINV = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;
   localparam logic signed [IN_W-1:0] N_LIMIT = IN_W'(MAX_N);

   logic [RES_W-1:0] fact_mem [MAX_N+1];
   logic [RES_W-1:0] finv_mem [MAX_N+1];
   logic [RES_W-1:0] inv_mem  [MAX_N+1];

   logic [3:0]       state_ff, state_in;
   logic             ready_ff, ready_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [K_W-1:0]   rem_ff, rem_in;
   logic [RES_W-1:0] quo_ff, quo_in;
   logic [RES_W-1:0] invk_ff, invk_in;
   logic [RES_W-1:0] fprev_ff, fprev_in;
   logic [RES_W-1:0] fiprev_ff, fiprev_in;
   logic [K_W:0]     rem2;
   logic             div_bit;

   logic             we;
   logic [IDX_W-1:0] waddr;
   logic [RES_W-1:0] inv_wdata, fact_wdata, finv_wdata;
   logic             inv_we, fact_we, finv_we;
   logic [RES_W-1:0] inv_rd_ff;

   logic             b_issue;
   logic [RES_W-1:0] b_a, b_b;

   ctl_type          ctl1_ff, ctl1_in, ctl2_ff;
   logic [IDX_W-1:0] an_ff, ad_ff, ar_ff;
   logic [RES_W-1:0] fact_rd_ff, finvd_rd_ff, finvr_rd_ff;
   logic             ok_in;
   logic signed [IN_W-1:0] diff;
   ctl_type          cline_ff [2*MM_LAT];
   logic [RES_W-1:0] rline_ff [MM_LAT];

   logic             ma_valid_in, ma_valid, mb_valid;
   logic [RES_W-1:0] ma_a, ma_b, ma_y, mb_b, mb_y;
   ctl_type          ctl_out;

   logic             rsp_valid_ff, rsp_oor_ff;
   logic [RES_W-1:0] rsp_value_ff;

   assign rem2 = {rem_ff, div_bit};
   assign div_bit = P_VAL[cnt_ff];

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      invk_in = invk_ff;
      fprev_in = fprev_ff;
      fiprev_in = fiprev_ff;
      we = 1'b0;
      inv_we = 1'b0;
      fact_we = 1'b0;
      finv_we = 1'b0;
      waddr = k_ff[IDX_W-1:0];
      inv_wdata = ma_y;
      fact_wdata = ma_y;
      finv_wdata = ma_y;
      b_issue = 1'b0;
      b_a = inv_rd_ff;
      b_b = quo_ff;
      unique case (state_ff) inside
         ST_INIT0, ST_INIT1: begin
            we = 1'b1;
            waddr = (state_ff == ST_INIT0) ? IDX_W'(0) : IDX_W'(1);
            inv_wdata = RES_W'(1);
            fact_wdata = RES_W'(1);
            finv_wdata = RES_W'(1);
            fprev_in = RES_W'(1);
            fiprev_in = RES_W'(1);
            k_in = K_W'(2);
            rem_in = '0;
            cnt_in = CNT_W'(RES_W - 1);
            state_in = (state_ff == ST_INIT0) ? ST_INIT1 : ST_DIV;
         end
         ST_DIV: begin
            if (rem2 >= (K_W+1)'(k_ff)) begin
               rem_in = K_W'(rem2 - (K_W+1)'(k_ff));
               quo_in = {quo_ff[RES_W-2:0], 1'b1};
            end else begin
               rem_in = K_W'(rem2);
               quo_in = {quo_ff[RES_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_MINV;
         end
         ST_MINV: begin
            b_issue = 1'b1;
            state_in = ST_WINV;
         end
         ST_WINV: begin
            if (ma_valid) begin
               inv_wdata = (ma_y == '0) ? '0 : P_VAL - ma_y;
               inv_we = 1'b1;
               invk_in = inv_wdata;
               state_in = ST_MFACT;
            end
         end
         ST_MFACT: begin
            b_issue = 1'b1;
            b_a = RES_W'(k_ff);
            b_b = fprev_ff;
            state_in = ST_WFACT;
         end
         ST_WFACT: begin
            if (ma_valid) begin
               fact_we = 1'b1;
               fprev_in = ma_y;
               state_in = ST_MFINV;
            end
         end
         ST_MFINV: begin
            b_issue = 1'b1;
            b_a = invk_ff;
            b_b = fiprev_ff;
            state_in = ST_WFINV;
         end
         ST_WFINV: begin
            if (ma_valid) begin
               finv_we = 1'b1;
               fiprev_in = ma_y;
               rem_in = '0;
               cnt_in = CNT_W'(RES_W - 1);
               if (k_ff == K_W'(MAX_N)) begin
                  ready_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + K_W'(1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DONE: begin
            ready_in = 1'b1;
         end
         default: begin
            state_in = ST_INIT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      invk_ff <= invk_in;
      fprev_ff <= fprev_in;
      fiprev_ff <= fiprev_in;
   end

   always_ff @(posedge clock) begin
      if (we || inv_we) begin
         inv_mem[waddr] <= inv_wdata;
      end
      inv_rd_ff <= inv_mem[rem_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we || fact_we) begin
         fact_mem[waddr] <= fact_wdata;
      end
      fact_rd_ff <= fact_mem[an_ff];
   end

   always_ff @(posedge clock) begin
      if (we || finv_we) begin
         finv_mem[waddr] <= finv_wdata;
      end
      finvd_rd_ff <= finv_mem[ad_ff];
      finvr_rd_ff <= finv_mem[ar_ff];
   end

   assign busy = !ready_ff;
   assign diff = req_n - req_r;
   assign ok_in = (req_n >= 0) && (req_r >= 0) && (req_r <= req_n) && (req_n <= N_LIMIT);

   always_comb begin
      ctl1_in.valid = start && ready_ff;
      ctl1_in.kind = req_type;
      ctl1_in.ok = ok_in;
      ctl1_in.oor = req_n > N_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         for (int i = 0; i < 2*MM_LAT; i++) begin
            cline_ff[i] <= '0;
         end
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         cline_ff[0] <= ctl2_ff;
         for (int i = 1; i < 2*MM_LAT; i++) begin
            cline_ff[i] <= cline_ff[i-1];
         end
      end
      an_ff <= IDX_W'(req_n);
      ad_ff <= IDX_W'(diff);
      ar_ff <= IDX_W'(req_r);
      rline_ff[0] <= finvr_rd_ff;
      for (int i = 1; i < MM_LAT; i++) begin
         rline_ff[i] <= rline_ff[i-1];
      end
   end

   assign ma_valid_in = ready_ff ? ctl2_ff.valid : b_issue;
   assign ma_a = ready_ff ? fact_rd_ff : b_a;
   assign ma_b = ready_ff ? finvd_rd_ff : b_b;

   bcmp_modmul u_mul_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ma_valid_in),
      .a         (ma_a),
      .b         (ma_b),
      .out_valid (ma_valid),
      .y         (ma_y)
   );

   assign mb_b = cline_ff[MM_LAT-1].kind ? RES_W'(1) : rline_ff[MM_LAT-1];

   bcmp_modmul u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ready_ff && ma_valid),
      .a         (ma_y),
      .b         (mb_b),
      .out_valid (mb_valid),
      .y         (mb_y)
   );

   assign ctl_out = cline_ff[2*MM_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_out.valid && mb_valid;
      end
      rsp_oor_ff <= ctl_out.oor;
      rsp_value_ff <= ctl_out.ok ? mb_y : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = VALUE_W'(rsp_value_ff);
   assign rsp_out_of_range = rsp_oor_ff;
endmodule
`default_nettype wire

>>> hdl/bcmp_modmul.sv
// Six-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none
module bcmp_modmul
   import bcmp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [RES_W-1:0] a,
   input  wire logic [RES_W-1:0] b,
   output logic                  out_valid,
   output logic [RES_W-1:0]      y
);
   logic [MM_LAT-1:0]     v_ff, v_in;
   logic [2*RES_W-1:0]    x1_ff, x2_ff, x3_ff, x4_ff;
   logic [2*RES_W:0]      ph_ff, pl_ff;
   logic [3*RES_W+1:0]    sum;
   logic [RES_W:0]        q_ff;
   logic [2*RES_W+1:0]    qp_ff;
   logic [RES_W+1:0]      r_ff, r_in;
   logic [RES_W-1:0]      y_ff, y_in;
   logic [RES_W+1:0]      p1, p2;

   assign v_in = {v_ff[MM_LAT-2:0], in_valid};
   assign sum = {ph_ff, {RES_W{1'b0}}} + (3*RES_W+2)'(pl_ff);
   assign r_in = x4_ff[RES_W+1:0] - qp_ff[RES_W+1:0];
   assign p1 = (RES_W+2)'(P_VAL);
   assign p2 = p1 << 1;

   always_comb begin
      if (r_ff >= p2) begin
         y_in = RES_W'(r_ff - p2);
      end else if (r_ff >= p1) begin
         y_in = RES_W'(r_ff - p1);
      end else begin
         y_in = RES_W'(r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      x1_ff <= (2*RES_W)'(a) * (2*RES_W)'(b);
      ph_ff <= (2*RES_W+1)'(x1_ff[2*RES_W-1:RES_W]) * (2*RES_W+1)'(MU);
      pl_ff <= (2*RES_W+1)'(x1_ff[RES_W-1:0]) * (2*RES_W+1)'(MU);
      x2_ff <= x1_ff;
      q_ff <= sum[3*RES_W:2*RES_W];
      x3_ff <= x2_ff;
      qp_ff <= (2*RES_W+2)'(q_ff) * (2*RES_W+2)'(P_VAL);
      x4_ff <= x3_ff;
      r_ff <= r_in;
      y_ff <= y_in;
   end

   assign out_valid = v_ff[MM_LAT-1];
   assign y = y_ff;
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the binomial coefficient block: directed and random requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import bcmp_pkg::*;

   localparam logic KIND_NCR = 1'b0;
   localparam logic KIND_NPR = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_type = 1'b0;
   logic signed [IN_W-1:0] req_n = '0;
   logic signed [IN_W-1:0] req_r = '0;
   logic busy;
   logic rsp_valid;
   logic [VALUE_W-1:0] rsp_value;
   logic rsp_out_of_range;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic out_of_range;
   } answer_type;

   answer_type pending_answers[$];
   longint unsigned fact[0:MAX_N];
   longint unsigned inv_fact[0:MAX_N];
   int errors = 0;
   int requests_sent = 0;
   int answers_checked = 0;
   int oor_seen = 0;
   int zero_seen = 0;

   binomial_coefficient_mod_prime dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_n(req_n), .req_r(req_r),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_out_of_range(rsp_out_of_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return (a * b) % longint'(MODULUS);
   endfunction

   function automatic void build_tables();
      longint unsigned inv[0:MAX_N];
      longint unsigned p;
      p = MODULUS;
      inv[0] = 1; inv[1] = 1;
      fact[0] = 1; fact[1] = 1;
      inv_fact[0] = 1; inv_fact[1] = 1;
      for (int k = 2; k <= MAX_N; k++) begin
         inv[k] = (p - mul_mod(inv[p % k], p / k)) % p;
         fact[k] = mul_mod(k, fact[k-1]);
         inv_fact[k] = mul_mod(inv[k], inv_fact[k-1]);
      end
   endfunction

   function automatic answer_type count_arrangements(logic kind, logic signed [IN_W-1:0] n,
                                                     logic signed [IN_W-1:0] r);
      answer_type a;
      longint unsigned v;
      int ni, ri;
      ni = n;
      ri = r;
      v = 0;
      a.out_of_range = 1'b0;
      if (ni > int'(MAX_N)) begin
         a.out_of_range = 1'b1;
      end else if (ni >= 0 && ri >= 0 && ri <= ni) begin
         v = mul_mod(fact[ni], inv_fact[ni-ri]);
         if (kind == KIND_NCR) begin
            v = mul_mod(v, inv_fact[ri]);
         end
      end
      a.value = v[VALUE_W-1:0];
      return a;
   endfunction

   // Drives one request and holds it until the block accepts it.
   task automatic send_request(logic kind, logic signed [IN_W-1:0] n,
                               logic signed [IN_W-1:0] r);
      start <= 1'b1;
      req_type <= kind;
      req_n <= n;
      req_r <= r;
      do @(posedge clock); while (busy);
      pending_answers.push_back(count_arrangements(kind, n, r));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic idle_cycles(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response value=%0d oor=%0b", rsp_value, rsp_out_of_range);
            errors++;
         end else begin
            e = pending_answers.pop_front();
            answers_checked++;
            if (rsp_out_of_range) oor_seen++;
            if (rsp_value == 0) zero_seen++;
            if (rsp_value !== e.value) begin
               $error("value: expected %0d, actual %0d", e.value, rsp_value);
               errors++;
            end
            if (rsp_out_of_range !== e.out_of_range) begin
               $error("out_of_range: expected %0b, actual %0b", e.out_of_range,
                      rsp_out_of_range);
               errors++;
            end
         end
      end
   end

   task automatic test_field_extremes();
      logic signed [IN_W-1:0] edges[8];
      edges = '{12'sd0, 12'sd1, 12'sd1023, 12'sd1024, 12'sd2047, -12'sd1, -12'sd2048, 12'sd512};
      foreach (edges[i]) begin
         send_request(KIND_NCR, edges[i], edges[(i + 3) % 8]);
         send_request(KIND_NPR, edges[i], edges[i]);
      end
      send_request(KIND_NCR, 12'sd1023, 12'sd511);
      send_request(KIND_NPR, 12'sd1023, 12'sd1023);
      send_request(KIND_NCR, 12'sd10, 12'sd11);
      send_request(KIND_NPR, -12'sd5, 12'sd0);
      send_request(KIND_NCR, 12'sd2000, -12'sd3);
      idle_cycles(1);
   endtask

   task automatic test_random_requests(int count);
      int burst;
      logic signed [IN_W-1:0] n, r;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++) begin
            case ($urandom_range(0, 9))
               0: begin n = IN_W'($urandom); r = IN_W'($urandom); end
               1: begin n = IN_W'($urandom_range(1024, 2047)); r = IN_W'($urandom); end
               2: begin
                  n = IN_W'($urandom_range(0, 1023));
                  r = IN_W'($urandom_range(0, 2047));
               end
               default: begin
                  n = IN_W'($urandom_range(0, 1023));
                  r = IN_W'($urandom_range(0, int'(n)));
               end
            endcase
            send_request(1'($urandom_range(0, 1)), n, r);
            count--;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      end
      idle_cycles(1);
   endtask

   task automatic wait_for_drain();
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      build_tables();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_random_requests(1130);
      wait_for_drain();
      $display("Sent %0d requests, checked %0d responses (%0d out of range, %0d zero).",
               requests_sent, answers_checked, oor_seen, zero_seen);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
